[design/grid_ray_wall_caster_macros.svh]
// assertion helpers
`ifndef GRID_RAY_WALL_CASTER_MACROS_SVH
`define GRID_RAY_WALL_CASTER_MACROS_SVH
`define GRWC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GRWC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

[design/grwc_pkg.sv]
`default_nettype none
package grwc_pkg;
	localparam int MAP_ROWS_DEF = 16;
	localparam int MAP_COLS_DEF = 32;
	localparam int TILE_PIXELS_DEF = 64;
	localparam int STRIP_COUNT_DEF = 1024;
	localparam int CORDIC_STEPS = 15;
	localparam logic [31:0] RATIO_MAX = 32'h7FFF_FFFF;
	localparam logic [19:0] DIST_ALL_ONES = 20'hFFFFF;
	localparam logic [18:0] HITX_MAX = 19'h7FFFF;
	localparam logic [17:0] HITY_MAX = 18'h3FFFF;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CAST = 1'b1;

	function automatic logic [13:0] atan_unit(input logic [3:0] i);
		logic [13:0] r;
		unique case (i)
			4'd0: r = 14'd8192;
			4'd1: r = 14'd4836;
			4'd2: r = 14'd2555;
			4'd3: r = 14'd1297;
			4'd4: r = 14'd651;
			4'd5: r = 14'd326;
			4'd6: r = 14'd163;
			4'd7: r = 14'd81;
			4'd8: r = 14'd41;
			4'd9: r = 14'd20;
			4'd10: r = 14'd10;
			4'd11: r = 14'd5;
			4'd12: r = 14'd3;
			4'd13: r = 14'd1;
			4'd14: r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

[design/grwc_if.sv]
`default_nettype none
interface grwc_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [3:0] tile_row;
	logic [4:0] tile_col;
	logic [3:0] tile_value;
	logic [18:0] origin_x;
	logic [17:0] origin_y;
	logic [15:0] ray_angle;
	logic [9:0] strip_index;
	modport source(output valid, kind, tile_row, tile_col, tile_value, origin_x, origin_y,
		ray_angle, strip_index, input ready);
	modport sink(input valid, kind, tile_row, tile_col, tile_value, origin_x, origin_y,
		ray_angle, strip_index, output ready);
endinterface

interface grwc_out_if;
	logic valid;
	logic ready;
	logic [9:0] strip_tag;
	logic [19:0] hit_distance;
	logic [18:0] hit_x;
	logic [17:0] hit_y;
	logic [3:0] hit_code;
	logic hit_vertical;
	logic [15:0] angle_out;
	modport source(output valid, strip_tag, hit_distance, hit_x, hit_y, hit_code,
		hit_vertical, angle_out, input ready);
	modport sink(input valid, strip_tag, hit_distance, hit_x, hit_y, hit_code,
		hit_vertical, angle_out, output ready);
endinterface
`default_nettype wire

[design/grid_ray_wall_caster.sv]
// channel | dir | contents
// ray_in  | in  | kind, tile fields, origin, angle, strip index
// hit_out | out | strip tag, distance, hit point, code, side, angle
// A ray runs 15 CORDIC steps, two 41-step ratio divisions, two walks of up to
// rows+1 and cols+1 probes, each passing through check, synchronous map read and
// evaluate, and two 22-step square roots.
// After reset a clearing pass writes zero to all rows*cols tiles, one a cycle,
// before the first item is taken. One item at a time; a held result does not stop
// the next item from being accepted, a finished ray waits until the output drains.
`default_nettype none
`include "grid_ray_wall_caster_macros.svh"
module grid_ray_wall_caster #(
	parameter int MAP_ROWS = grwc_pkg::MAP_ROWS_DEF,
	parameter int MAP_COLS = grwc_pkg::MAP_COLS_DEF,
	parameter int TILE_PIXELS = grwc_pkg::TILE_PIXELS_DEF
) (
	input wire clk,
	input wire arst_n,
	grwc_in_if.sink ray_in,
	grwc_out_if.source hit_out
);
	localparam int DEPTH = MAP_ROWS * MAP_COLS;
	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(MAP_ROWS);
	localparam int CW = $clog2(MAP_COLS);
	localparam int TSH = $clog2(TILE_PIXELS) + 8;
	localparam logic signed [23:0] T8 = 24'(TILE_PIXELS * 256);
	localparam logic signed [31:0] WIDTH8 = 32'(MAP_COLS * TILE_PIXELS * 256);
	localparam logic signed [31:0] HEIGHT8 = 32'(MAP_ROWS * TILE_PIXELS * 256);

	localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_CORDIC = 4'd2,
		ST_DIV = 4'd3, ST_SETUP = 4'd4, ST_CHECK = 4'd5, ST_READ = 4'd6,
		ST_EVAL = 4'd7, ST_SQRT = 4'd8, ST_DONE = 4'd9;

	logic [3:0] state_q;
	logic [AW-1:0] clr_q;
	logic [3:0] tile_mem [DEPTH];
	logic [3:0] rd_data_s1;

	logic [9:0] tag_q;
	logic [15:0] ang_q;
	logic signed [23:0] x0_q, y0_q;
	logic down_q, right_q;
	logic signed [17:0] zc_q;
	logic signed [26:0] cx_q, cy_q;
	logic [3:0] it_q;
	logic [24:0] cmag_q, smag_q;
	logic [31:0] tan_q, cot_q;
	logic [5:0] dcnt_q;
	logic dsel_q;
	logic [48:0] rem_q;
	logic [40:0] num_q;
	logic [31:0] quo_q;
	logic walk_q;
	// walk positions run far off the map on steep rays
	logic signed [39:0] px_q, py_q, sx_q, sy_q;
	logic signed [39:0] offx_q, offy_q;
	logic hf_q, vf_q;
	logic signed [23:0] hx_q, hy_q, vx_q, vy_q;
	logic [3:0] hc_q, vc_q;
	logic [40:0] hd_q, vd_q;
	logic [43:0] sv_q, sr_q, sb_q;
	logic sq_q;
	logic [AW-1:0] rd_addr_q;
	logic oob_q;

	logic [9:0] o_tag_q;
	logic [19:0] o_dist_q;
	logic [18:0] o_x_q;
	logic [17:0] o_y_q;
	logic [3:0] o_code_q;
	logic o_vert_q, o_valid_q;
	logic [15:0] o_ang_q;

	logic in_fire;
	logic [48:0] trial;
	logic signed [39:0] qx, qy;
	logic [40:0] ad2;
	logic [23:0] adx, ady;
	logic [43:0] s_try;
	logic signed [17:0] z0;
	logic [31:0] ratio_sel;
	logic [23:0] edge_y, edge_x, dlen;
	logic [55:0] prod_off, prod_st;
	logic signed [39:0] off_w, st_w;
	logic slot_free;

	assign slot_free = !o_valid_q || hit_out.ready;
	assign ray_in.ready = (state_q == ST_IDLE);
	assign in_fire = ray_in.valid && ray_in.ready;

	always_comb begin
		z0 = {2'b00, ray_in.ray_angle};
		if (z0 >= 18'sd32768) z0 = z0 - 18'sd65536;
		if (z0 > 18'sd16384) z0 = z0 - 18'sd32768;
		else if (z0 < -18'sd16384) z0 = z0 + 18'sd32768;
	end

	// truncate toward zero like C division
	function automatic logic signed [26:0] sdiv(input logic signed [26:0] v,
		input logic [3:0] s);
		logic signed [26:0] a;
		a = v < 0 ? -v : v;
		a = a >>> s;
		return v < 0 ? -a : a;
	endfunction

	assign qx = px_q + offx_q;
	assign qy = py_q + offy_q;
	assign trial = {rem_q[47:0], num_q[40]} - {24'd0, dsel_q ? smag_q : cmag_q};
	assign ratio_sel = walk_q ? tan_q : cot_q;
	assign edge_y = 24'((y0_q >>> TSH) <<< TSH);
	assign edge_x = 24'((x0_q >>> TSH) <<< TSH);
	assign dlen = walk_q ? (right_q ? 24'(edge_x + T8 - x0_q) : 24'(x0_q - edge_x))
		: (down_q ? 24'(edge_y + T8 - y0_q) : 24'(y0_q - edge_y));
	assign prod_off = 56'(dlen) * 56'(ratio_sel);
	assign prod_st = 56'(T8) * 56'(ratio_sel);
	assign off_w = $signed(40'(prod_off >> 16));
	assign st_w = $signed(40'(prod_st >> 16));
	assign adx = walk_q ? 24'(vx_q >= x0_q ? vx_q - x0_q : x0_q - vx_q)
		: 24'(hx_q >= x0_q ? hx_q - x0_q : x0_q - hx_q);
	assign ady = walk_q ? 24'(vy_q >= y0_q ? vy_q - y0_q : y0_q - vy_q)
		: 24'(hy_q >= y0_q ? hy_q - y0_q : y0_q - hy_q);
	assign ad2 = 41'(adx) * 41'(adx) + 41'(ady) * 41'(ady);
	assign s_try = sr_q + sb_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) tile_mem[clr_q] <= 4'd0;
		else if (in_fire && ray_in.kind == grwc_pkg::KIND_WRITE
			&& 32'(ray_in.tile_row) < MAP_ROWS && 32'(ray_in.tile_col) < MAP_COLS)
			tile_mem[AW'(32'(ray_in.tile_row) * MAP_COLS + 32'(ray_in.tile_col))]
				<= ray_in.tile_value;
		rd_data_s1 <= tile_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			o_valid_q <= (o_valid_q && !hit_out.ready) || (state_q == ST_DONE && slot_free);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_fire && ray_in.kind == grwc_pkg::KIND_CAST) begin
						tag_q <= ray_in.strip_index;
						ang_q <= ray_in.ray_angle;
						x0_q <= 24'(ray_in.origin_x);
						y0_q <= 24'(ray_in.origin_y);
						down_q <= ray_in.ray_angle > 16'd0 && ray_in.ray_angle < 16'd32768;
						right_q <= ray_in.ray_angle < 16'd16384
							|| ray_in.ray_angle > 16'd49152;
						zc_q <= z0;
						cx_q <= 27'sd16777216;
						cy_q <= '0;
						it_q <= '0;
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (zc_q >= 0) begin
						cx_q <= cx_q - sdiv(cy_q, it_q);
						cy_q <= cy_q + sdiv(cx_q, it_q);
						zc_q <= zc_q - 18'(grwc_pkg::atan_unit(it_q));
					end else begin
						cx_q <= cx_q + sdiv(cy_q, it_q);
						cy_q <= cy_q - sdiv(cx_q, it_q);
						zc_q <= zc_q + 18'(grwc_pkg::atan_unit(it_q));
					end
					it_q <= it_q + 1'b1;
					if (32'(it_q) == grwc_pkg::CORDIC_STEPS - 1) state_q <= ST_DIV;
					dcnt_q <= '0;
					dsel_q <= 1'b0;
					rem_q <= '0;
					quo_q <= '0;
				end
				ST_DIV: begin
					if (dcnt_q == 6'd0 && !dsel_q) begin
						cmag_q <= (ang_q == 16'd16384 || ang_q == 16'd49152) ? 25'd0
							: 25'(cx_q < 0 ? -cx_q : cx_q);
						smag_q <= (ang_q == 16'd0 || ang_q == 16'd32768) ? 25'd0
							: 25'(cy_q < 0 ? -cy_q : cy_q);
						num_q <= (ang_q == 16'd0 || ang_q == 16'd32768) ? 41'd0
							: 41'(cy_q < 0 ? -cy_q : cy_q) << 16;
						dcnt_q <= 6'd1;
					end else if (dcnt_q <= 6'd41) begin
						// restoring division, one quotient bit a cycle
						if (!trial[48]) begin
							rem_q <= trial;
							quo_q <= {quo_q[30:0], 1'b1} | {32{quo_q[31]}};
						end else begin
							rem_q <= {rem_q[47:0], num_q[40]};
							quo_q <= {quo_q[30:0], 1'b0} | {32{quo_q[31]}};
						end
						num_q <= num_q << 1;
						dcnt_q <= dcnt_q + 1'b1;
					end else begin
						if (!dsel_q) begin
							tan_q <= (cmag_q == 0 || quo_q > grwc_pkg::RATIO_MAX)
								? grwc_pkg::RATIO_MAX : quo_q;
							dsel_q <= 1'b1;
							num_q <= 41'(cmag_q) << 16;
							rem_q <= '0;
							quo_q <= '0;
							dcnt_q <= 6'd1;
						end else begin
							cot_q <= (smag_q == 0 || quo_q > grwc_pkg::RATIO_MAX)
								? grwc_pkg::RATIO_MAX : quo_q;
							walk_q <= 1'b0;
							hf_q <= 1'b0;
							vf_q <= 1'b0;
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					if (!walk_q) begin
						py_q <= down_q ? 40'(edge_y + T8) : 40'(edge_y);
						px_q <= right_q ? 40'(x0_q) + off_w : 40'(x0_q) - off_w;
						sy_q <= down_q ? 40'(T8) : -40'(T8);
						sx_q <= right_q ? st_w : -st_w;
						offx_q <= '0;
						offy_q <= down_q ? 40'sd0 : -40'sd256;
						state_q <= (smag_q != 0) ? ST_CHECK : ST_SETUP;
						if (smag_q == 0) walk_q <= 1'b1;
					end else begin
						px_q <= right_q ? 40'(edge_x + T8) : 40'(edge_x);
						py_q <= down_q ? 40'(y0_q) + off_w : 40'(y0_q) - off_w;
						sx_q <= right_q ? 40'(T8) : -40'(T8);
						sy_q <= down_q ? st_w : -st_w;
						offx_q <= right_q ? 40'sd0 : -40'sd256;
						offy_q <= '0;
						state_q <= (cmag_q != 0) ? ST_CHECK : ST_SQRT;
					end
					sq_q <= 1'b0;
				end
				ST_CHECK: begin
					if (px_q >= 0 && py_q >= 0 && px_q <= WIDTH8 && py_q <= HEIGHT8) begin
						oob_q <= qx < 0 || qy < 0 || qx >= WIDTH8 || qy >= HEIGHT8;
						rd_addr_q <= AW'(((qy >>> TSH) * MAP_COLS) + (qx >>> TSH));
						state_q <= ST_READ;
					end else if (!walk_q) begin
						walk_q <= 1'b1;
						state_q <= ST_SETUP;
					end else state_q <= ST_SQRT;
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (oob_q || rd_data_s1 != 4'd0) begin
						if (!walk_q) begin
							hf_q <= 1'b1; hx_q <= 24'(px_q); hy_q <= 24'(py_q);
							hc_q <= oob_q ? 4'd0 : rd_data_s1;
							walk_q <= 1'b1;
							state_q <= ST_SETUP;
						end else begin
							vf_q <= 1'b1; vx_q <= 24'(px_q); vy_q <= 24'(py_q);
							vc_q <= oob_q ? 4'd0 : rd_data_s1;
							state_q <= ST_SQRT;
						end
					end else begin
						px_q <= px_q + sx_q;
						py_q <= py_q + sy_q;
						state_q <= ST_CHECK;
					end
				end
				// vertical hit length first, then horizontal
				ST_SQRT: begin
					if (!sq_q) begin
						sq_q <= 1'b1;
						sv_q <= 44'(ad2);
						sr_q <= '0;
						sb_q <= 44'd1 << 42;
					end else if (sb_q != 0) begin
						if (sv_q >= s_try) begin
							sv_q <= sv_q - s_try;
							sr_q <= (sr_q >> 1) + sb_q;
						end else sr_q <= sr_q >> 1;
						sb_q <= sb_q >> 2;
					end else begin
						if (walk_q) begin
							vd_q <= vf_q ? 41'(sr_q) : '1;
							walk_q <= 1'b0;
							sq_q <= 1'b0;
						end else begin
							hd_q <= hf_q ? 41'(sr_q) : '1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						o_tag_q <= tag_q;
						o_ang_q <= ang_q;
						if (vd_q < hd_q) begin
							o_dist_q <= vd_q > 41'(grwc_pkg::DIST_ALL_ONES)
								? grwc_pkg::DIST_ALL_ONES : 20'(vd_q);
							o_x_q <= vx_q > 24'(grwc_pkg::HITX_MAX) ? grwc_pkg::HITX_MAX
								: 19'(vx_q);
							o_y_q <= vy_q > 24'(grwc_pkg::HITY_MAX) ? grwc_pkg::HITY_MAX
								: 18'(vy_q);
							o_code_q <= vc_q;
							o_vert_q <= 1'b1;
						end else begin
							o_dist_q <= hd_q > 41'(grwc_pkg::DIST_ALL_ONES)
								? grwc_pkg::DIST_ALL_ONES : 20'(hd_q);
							o_x_q <= !hf_q ? 19'd0 : hx_q > 24'(grwc_pkg::HITX_MAX)
								? grwc_pkg::HITX_MAX : 19'(hx_q);
							o_y_q <= !hf_q ? 18'd0 : hy_q > 24'(grwc_pkg::HITY_MAX)
								? grwc_pkg::HITY_MAX : 18'(hy_q);
							o_code_q <= hf_q ? hc_q : 4'd0;
							o_vert_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign hit_out.valid = o_valid_q;
	assign hit_out.strip_tag = o_tag_q;
	assign hit_out.hit_distance = o_dist_q;
	assign hit_out.hit_x = o_x_q;
	assign hit_out.hit_y = o_y_q;
	assign hit_out.hit_code = o_code_q;
	assign hit_out.hit_vertical = o_vert_q;
	assign hit_out.angle_out = o_ang_q;

	`GRWC_NEVER(a_no_accept_busy, ray_in.ready && state_q != ST_IDLE, "ready while busy")
	`GRWC_ASSERT(a_result_from_done, $rose(o_valid_q) |-> $past(state_q) == ST_DONE,
		"result not from done")
	`GRWC_ASSERT(a_ray_starts, (in_fire && ray_in.kind == grwc_pkg::KIND_CAST)
		|=> state_q == ST_CORDIC, "ray did not start")
	`GRWC_ASSERT(a_hold_out, (o_valid_q && !hit_out.ready) |=> o_valid_q && $stable(o_tag_q),
		"result dropped")
endmodule
`default_nettype wire
